/* hdl/tbpq_pkg.sv */
// Package for the three-level bounded priority queue.
// Holds level depths, data and result types, and operation and status codes.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package tbpq_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int LEVEL_COUNT = 3;
	localparam int LEVEL_ONE_DEPTH = 3;
	localparam int LEVEL_TWO_DEPTH = 2;
	localparam int LEVEL_THREE_DEPTH = 1;
	localparam int LEVEL_DEPTH [LEVEL_COUNT] = '{LEVEL_ONE_DEPTH, LEVEL_TWO_DEPTH,
		LEVEL_THREE_DEPTH};

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [1:0] level_t;
	typedef logic [1:0] status_t;
	typedef logic kind_t;

	localparam kind_t KIND_INSERT = 1'b0;
	localparam kind_t KIND_REMOVE = 1'b1;

	localparam level_t LEVEL_NONE = 2'd0;
	localparam level_t LEVEL_ONE = 2'd1;
	localparam level_t LEVEL_TWO = 2'd2;
	localparam level_t LEVEL_THREE = 2'd3;

	localparam status_t STATUS_INSERTED = 2'd0;
	localparam status_t STATUS_OVERFLOW = 2'd1;
	localparam status_t STATUS_REMOVED = 2'd2;
	localparam status_t STATUS_UNDERFLOW = 2'd3;

	typedef struct packed {
		logic [LEVEL_COUNT-1:0] full;
		logic [LEVEL_COUNT-1:0] nonempty;
	} level_flags_t;

	typedef struct packed {
		logic [LEVEL_COUNT-1:0] push;
		logic [LEVEL_COUNT-1:0] pop;
		data_t word;
	} level_op_t;

	typedef struct packed {
		status_t status;
		level_t placed_level;
		data_t removed_value;
	} result_t;

endpackage

/* hdl/tbpq_req_if.sv */
// Request channel of the priority queue: valid/ready handshake with the operation payload.
// Depends on tbpq_pkg for the field types.
`timescale 1ns / 1ps

interface tbpq_req_if;
	logic valid;
	logic ready;
	tbpq_pkg::kind_t kind;
	tbpq_pkg::data_t entry_value;
	tbpq_pkg::level_t wanted_level;

	modport source (output valid, output kind, output entry_value, output wanted_level,
		input ready);
	modport sink (input valid, input kind, input entry_value, input wanted_level,
		output ready);
endinterface

/* hdl/tbpq_rsp_if.sv */
// Response channel of the priority queue: valid/ready handshake with the result payload.
// Depends on tbpq_pkg for the field types.
`timescale 1ns / 1ps

interface tbpq_rsp_if;
	logic valid;
	logic ready;
	tbpq_pkg::status_t status;
	tbpq_pkg::level_t placed_level;
	tbpq_pkg::data_t removed_value;

	modport source (output valid, output status, output placed_level, output removed_value,
		input ready);
	modport sink (input valid, input status, input placed_level, input removed_value,
		output ready);
endinterface

/* hdl/tbpq_levels.sv */
// Storage of the three FIFO levels: data words, head pointers and fill counts.
// Depends on tbpq_pkg for depths, the operation struct and the flag struct.
`timescale 1ns / 1ps

module tbpq_levels (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbpq_pkg::level_op_t    op,
	output tbpq_pkg::level_flags_t flags,
	output tbpq_pkg::data_t        head_word [tbpq_pkg::LEVEL_COUNT]
);

	for (genvar g = 0; g < tbpq_pkg::LEVEL_COUNT; g++) begin : g_level
		localparam int D = tbpq_pkg::LEVEL_DEPTH[g];
		localparam int IW = (D > 1) ? $clog2(D) : 1;
		localparam int FW = $clog2(D + 1);
		localparam int SW = ((IW > FW) ? IW : FW) + 1;

		tbpq_pkg::data_t store_q [D];
		logic [IW-1:0] head_q;
		logic [FW-1:0] fill_q;
		logic [SW-1:0] tail_sum;
		logic [IW-1:0] tail;

		always_comb begin
			tail_sum = SW'(head_q) + SW'(fill_q);
			tail = (tail_sum >= SW'(D)) ? IW'(tail_sum - SW'(D)) : IW'(tail_sum);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				head_q <= '0;
				fill_q <= '0;
			end else if (op.push[g]) begin
				fill_q <= fill_q + 1'b1;
			end else if (op.pop[g]) begin
				head_q <= (head_q == IW'(D - 1)) ? '0 : head_q + 1'b1;
				fill_q <= fill_q - 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (op.push[g]) begin
				store_q[tail] <= op.word;
			end
		end

		assign flags.full[g] = (fill_q == FW'(D));
		assign flags.nonempty[g] = (fill_q != '0);
		assign head_word[g] = store_q[head_q];
	end

endmodule

/* hdl/tbpq_decide.sv */
// Decision logic of the priority queue: level selection with demotion on insert,
// selection of the lowest-numbered nonempty level on remove, and the result fields. Depends on tbpq_pkg.
`timescale 1ns / 1ps

module tbpq_decide (
	input  tbpq_pkg::kind_t        kind,
	input  tbpq_pkg::data_t        entry_value,
	input  tbpq_pkg::level_t       wanted_level,
	input  tbpq_pkg::level_flags_t flags,
	input  tbpq_pkg::data_t        head_word [tbpq_pkg::LEVEL_COUNT],
	output tbpq_pkg::level_op_t    op,
	output tbpq_pkg::result_t      result
);

	tbpq_pkg::level_t lvl;

	always_comb begin
		op.push = '0;
		op.pop = '0;
		op.word = entry_value;
		result.status = tbpq_pkg::STATUS_UNDERFLOW;
		result.placed_level = tbpq_pkg::LEVEL_NONE;
		result.removed_value = '0;
		lvl = (wanted_level == tbpq_pkg::LEVEL_NONE) ? tbpq_pkg::LEVEL_THREE : wanted_level;

		if (kind == tbpq_pkg::KIND_INSERT) begin
			if (lvl == tbpq_pkg::LEVEL_ONE && flags.full[0]) begin
				lvl = tbpq_pkg::LEVEL_TWO;
			end
			if (lvl == tbpq_pkg::LEVEL_TWO && flags.full[1]) begin
				lvl = tbpq_pkg::LEVEL_THREE;
			end
			if (lvl == tbpq_pkg::LEVEL_THREE && flags.full[2]) begin
				result.status = tbpq_pkg::STATUS_OVERFLOW;
			end else begin
				result.status = tbpq_pkg::STATUS_INSERTED;
				result.placed_level = lvl;
				case (lvl)
					tbpq_pkg::LEVEL_ONE: op.push[0] = 1'b1;
					tbpq_pkg::LEVEL_TWO: op.push[1] = 1'b1;
					default: op.push[2] = 1'b1;
				endcase
			end
		end else if (flags.nonempty[0]) begin
			op.pop[0] = 1'b1;
			result.status = tbpq_pkg::STATUS_REMOVED;
			result.placed_level = tbpq_pkg::LEVEL_ONE;
			result.removed_value = head_word[0];
		end else if (flags.nonempty[1]) begin
			op.pop[1] = 1'b1;
			result.status = tbpq_pkg::STATUS_REMOVED;
			result.placed_level = tbpq_pkg::LEVEL_TWO;
			result.removed_value = head_word[1];
		end else if (flags.nonempty[2]) begin
			op.pop[2] = 1'b1;
			result.status = tbpq_pkg::STATUS_REMOVED;
			result.placed_level = tbpq_pkg::LEVEL_THREE;
			result.removed_value = head_word[2];
		end
	end

endmodule

/* hdl/three_level_bounded_priority_queue_top.sv */
// Top level of the three-level bounded priority queue with demotion.
// Depends on tbpq_pkg, tbpq_req_if, tbpq_rsp_if, tbpq_levels and tbpq_decide.
//
//   Channel  Modport  Transaction payload
//   req      sink     kind, entry_value, wanted_level
//   rsp      source   status, placed_level, removed_value
//
// Each request transaction is held in an input register, is decided against the
// level state and is loaded into the result register when the input register advances.
// One transaction per cycle is sustained while the response is not stalled; a stalled
// response keeps the result register and then the input register waiting.
// The level state and the result are written at the same edge, so a following request
// sees the updated queue. Reset empties all levels and both pipeline registers.
// A stalled response holds the pipeline, and req.ready falls only when both stages are full.
`timescale 1ns / 1ps

module three_level_bounded_priority_queue_top (
	input  logic            clk,
	input  logic            arst_n,
	tbpq_req_if.sink        req,
	tbpq_rsp_if.source      rsp
);

	logic                   valid_s1;
	tbpq_pkg::kind_t        kind_s1;
	tbpq_pkg::data_t        value_s1;
	tbpq_pkg::level_t       level_s1;
	logic                   valid_s2;
	tbpq_pkg::result_t      result_s2;
	logic                   advance;
	tbpq_pkg::level_flags_t flags;
	tbpq_pkg::data_t        head_word [tbpq_pkg::LEVEL_COUNT];
	tbpq_pkg::level_op_t    op_raw;
	tbpq_pkg::level_op_t    op;
	tbpq_pkg::result_t      result;

	assign advance = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		op = op_raw;
		op.push = advance ? op_raw.push : '0;
		op.pop = advance ? op_raw.pop : '0;
	end

	tbpq_decide u_decide (
		.kind         (kind_s1),
		.entry_value  (value_s1),
		.wanted_level (level_s1),
		.flags        (flags),
		.head_word    (head_word),
		.op           (op_raw),
		.result       (result)
	);

	tbpq_levels u_levels (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.flags     (flags),
		.head_word (head_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			kind_s1 <= req.kind;
			value_s1 <= req.entry_value;
			level_s1 <= req.wanted_level;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.status = result_s2.status;
	assign rsp.placed_level = result_s2.placed_level;
	assign rsp.removed_value = result_s2.removed_value;

`ifndef NO_ASSERTIONS
	a_single_level_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({op.push, op.pop}))
		else $error("More than one level is written or read in one cycle.");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && !rsp.ready))
		else $error("Request side stalled without a full pipeline.");

	a_level_one_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.status == tbpq_pkg::STATUS_INSERTED &&
		result.placed_level == tbpq_pkg::LEVEL_ONE) |=> flags.nonempty[0])
		else $error("Insert into level one left it empty.");

	a_no_entry_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (result_s2.status == tbpq_pkg::STATUS_OVERFLOW ||
		result_s2.status == tbpq_pkg::STATUS_UNDERFLOW)) |->
		(result_s2.placed_level == tbpq_pkg::LEVEL_NONE && result_s2.removed_value == '0))
		else $error("Refused or empty result carries a level or a data word.");
`endif

endmodule
